/* sv/sync_frame_receiver_crc16_defines.svh */
// assertion macros for the frame receiver checker
`ifndef SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication, disabled in reset
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

/* sv/sfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam logic [1:0] FUNC_ARM  = 2'd0;
    localparam logic [1:0] FUNC_BYTE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CRC_BAD  = 3'd1;
    localparam logic [2:0] ST_CMD_BAD  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;

    localparam logic [7:0]  SYNC_A    = 8'h55;
    localparam logic [7:0]  SYNC_B    = 8'hAA;
    localparam logic [15:0] MIN_FRAME = 16'd7;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_EXPECTED_CMD  = 2'd0;
    localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  RST_EXPECTED_CMD  = 8'd0;
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd65528;
    localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd1000;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [7:0]  expected_cmd;
        logic [15:0] max_payload;
        logic [31:0] timeout_ticks;
    } cfg_t;

    // one byte of reflected crc-16, register holds {low, high}
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    localparam logic [15:0] CRC_AFTER_SYNC = crc_step(crc_step(CRC_INIT, SYNC_A), SYNC_B);

endpackage

`default_nettype wire

/* sv/sfr_channels.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if
    import sfr_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] byte_value;

    modport source (output valid, output func, output byte_value, input ready);
    modport sink (input valid, input func, input byte_value, output ready);
endinterface

interface sfr_out_if
    import sfr_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] payload_length;
    logic        last;

    modport source (output valid, output is_status, output data_byte, output status,
                    output payload_length, output last, input ready);
    modport sink (input valid, input is_status, input data_byte, input status,
                  input payload_length, input last, output ready);
endinterface

`default_nettype wire

/* sv/sfr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfr_front
    import sfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sfr_in_if.sink    items,
    input  wire logic pop,
    output logic      head_valid,
    output item_t     head
);

    item_t      mem_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       push;
    logic       take;

    assign items.ready = (count_reg != 2'd2);
    assign take        = items.valid && items.ready;
    // unused function code is dropped here
    assign push        = take && (items.func != FUNC_NONE);
    assign head_valid  = (count_reg != 2'd0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{func: items.func, byte_value: items.byte_value};
        end
    end

endmodule

`default_nettype wire

/* sv/sfr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic head_valid,
    input  wire item_t head,
    output logic      pop,
    sfr_out_if.source results
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HUNT  = 3'd1;
    localparam logic [2:0] PH_GOT55 = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_LENHI = 3'd4;
    localparam logic [2:0] PH_LENLO = 3'd5;
    localparam logic [2:0] PH_TAIL  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] tail_reg, tail_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_first_reg, crc_first_next;

    logic        out_valid_reg, out_valid_next;
    logic        is_status_reg, is_status_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] plen_out_reg, plen_out_next;

    logic        emit;
    logic [31:0] tick_sum;
    logic [15:0] len_word;
    logic [7:0]  b;

    assign pop      = head_valid && (!out_valid_reg || results.ready);
    assign b        = head.byte_value;
    assign tick_sum = elapsed_reg + 32'd1;
    assign len_word = {len_hi_reg, b};

    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        cmd_next       = cmd_reg;
        len_hi_next    = len_hi_reg;
        plen_next      = plen_reg;
        tail_next      = tail_reg;
        crc_next       = crc_reg;
        crc_first_next = crc_first_reg;
        emit           = 1'b0;
        is_status_next = 1'b0;
        data_next      = 8'd0;
        status_next    = ST_OK;
        plen_out_next  = 16'd0;

        if (pop)
        begin
            unique case (head.func)
                FUNC_ARM:
                begin
                    elapsed_next = 32'd0;
                    phase_next   = PH_HUNT;
                end
                FUNC_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        elapsed_next = tick_sum;
                        if (tick_sum >= cfg.timeout_ticks)
                        begin
                            phase_next     = PH_IDLE;
                            emit           = 1'b1;
                            is_status_next = 1'b1;
                            status_next    = ST_TIMEOUT;
                        end
                    end
                end
                FUNC_BYTE:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_HUNT:
                        begin
                            if (b == SYNC_A)
                            begin
                                phase_next = PH_GOT55;
                            end
                        end
                        PH_GOT55:
                        begin
                            if (b == SYNC_B)
                            begin
                                cmd_next       = 8'd0;
                                len_hi_next    = 8'd0;
                                tail_next      = 16'd0;
                                crc_first_next = 8'd0;
                                crc_next       = CRC_AFTER_SYNC;
                                phase_next     = PH_CMD;
                            end
                            else if (b != SYNC_A)
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_CMD:
                        begin
                            cmd_next   = b;
                            crc_next   = crc_step(crc_reg, b);
                            phase_next = PH_LENHI;
                        end
                        PH_LENHI:
                        begin
                            len_hi_next = b;
                            crc_next    = crc_step(crc_reg, b);
                            phase_next  = PH_LENLO;
                        end
                        PH_LENLO:
                        begin
                            crc_next = crc_step(crc_reg, b);
                            if (len_word < MIN_FRAME)
                            begin
                                phase_next     = PH_IDLE;
                                emit           = 1'b1;
                                is_status_next = 1'b1;
                                status_next    = ST_BAD_LEN;
                            end
                            else
                            begin
                                plen_next  = len_word - MIN_FRAME;
                                tail_next  = 16'd0;
                                phase_next = PH_TAIL;
                            end
                        end
                        PH_TAIL:
                        begin
                            if (tail_reg < plen_reg)
                            begin
                                crc_next  = crc_step(crc_reg, b);
                                tail_next = tail_reg + 16'd1;
                                if (tail_reg < cfg.max_payload)
                                begin
                                    emit          = 1'b1;
                                    data_next     = b;
                                    plen_out_next = plen_reg;
                                end
                            end
                            else if (tail_reg == plen_reg)
                            begin
                                crc_first_next = b;
                                tail_next      = tail_reg + 16'd1;
                            end
                            else
                            begin
                                phase_next     = PH_IDLE;
                                emit           = 1'b1;
                                is_status_next = 1'b1;
                                plen_out_next  = plen_reg;
                                if (crc_first_reg != crc_reg[7:0] || b != crc_reg[15:8])
                                begin
                                    status_next = ST_CRC_BAD;
                                end
                                else if (cmd_reg != cfg.expected_cmd)
                                begin
                                    status_next = ST_CMD_BAD;
                                end
                                else if (plen_reg > cfg.max_payload)
                                begin
                                    status_next = ST_TOO_LONG;
                                end
                                else
                                begin
                                    status_next = ST_OK;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= 32'd0;
            cmd_reg       <= 8'd0;
            len_hi_reg    <= 8'd0;
            plen_reg      <= 16'd0;
            tail_reg      <= 16'd0;
            crc_reg       <= CRC_INIT;
            crc_first_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            cmd_reg       <= cmd_next;
            len_hi_reg    <= len_hi_next;
            plen_reg      <= plen_next;
            tail_reg      <= tail_next;
            crc_reg       <= crc_next;
            crc_first_reg <= crc_first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            is_status_reg <= is_status_next;
            data_reg      <= data_next;
            status_reg    <= status_next;
            plen_out_reg  <= plen_out_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.is_status      = is_status_reg;
    assign results.data_byte      = data_reg;
    assign results.status         = status_reg;
    assign results.payload_length = plen_out_reg;
    assign results.last           = is_status_reg;

endmodule

`default_nettype wire

/* sv/sync_frame_receiver_crc16.sv */
// an input transaction passes through the queue and then the result register before its result appears
// throughput: one transaction per cycle while results are accepted, set by the combinational crc byte step
// a two-entry queue parts input and frame logic; a result register parts the output
// rst_n is asynchronous and active low: receiver idle, queue and result register empty
// configuration returns to its documented reset values
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_receiver_crc16
    import sfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    sfr_in_if.sink                  items,
    sfr_out_if.source               results,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t  cfg_reg;
    logic  wr_en;
    logic  pop;
    logic  head_valid;
    item_t head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_cmd  <= RST_EXPECTED_CMD;
            cfg_reg.max_payload   <= RST_MAX_PAYLOAD;
            cfg_reg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_EXPECTED_CMD:  cfg_reg.expected_cmd  <= pwdata[7:0];
                REG_MAX_PAYLOAD:   cfg_reg.max_payload   <= pwdata[15:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_EXPECTED_CMD:  prdata = {24'd0, cfg_reg.expected_cmd};
            REG_MAX_PAYLOAD:   prdata = {16'd0, cfg_reg.max_payload};
            REG_TIMEOUT_TICKS: prdata = cfg_reg.timeout_ticks;
            default:           prdata = 32'd0;
        endcase
    end

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

`default_nettype wire

/* sv/sfr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "sync_frame_receiver_crc16_defines.svh"

module sfr_checker
    import sfr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        is_status,
    input wire logic [7:0]  data_byte,
    input wire logic [2:0]  status,
    input wire logic [15:0] payload_length,
    input wire logic        last
);

    // a stalled result keeps its contents
    `SFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(status) && $stable(payload_length) && $stable(is_status))

    `SFR_ASSERT_IMPLY(a_last_on_status, clk, rst_n, out_valid, last == is_status)

    `SFR_ASSERT_IMPLY(a_payload_clean, clk, rst_n, out_valid && !is_status, status == ST_OK)

    `SFR_ASSERT_IMPLY(a_early_end_len, clk, rst_n, out_valid && is_status && (status == ST_BAD_LEN || status == ST_TIMEOUT), payload_length == 16'd0)

endmodule

bind sync_frame_receiver_crc16 sfr_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .is_status      (results.is_status),
    .data_byte      (results.data_byte),
    .status         (results.status),
    .payload_length (results.payload_length),
    .last           (results.last)
);

`default_nettype wire
